// ----- hw/rtl/mgr_pkg.sv -----
// ----------------------------------------------------------------------------
// mgr_pkg
// Event codes, stroke direction codes, command codes and register map of the
// mouse gesture recogniser, and the table that maps strokes to commands.
// ----------------------------------------------------------------------------
package mgr_pkg;

  // Pointer event codes (codes 5 to 7 behave as "other")
  typedef enum logic [2:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_MOVE    = 3'd2,
    CMD_MENU    = 3'd3,
    CMD_OTHER   = 3'd4
  } cmd_t;

  // Stroke directions
  typedef enum logic [1:0] {
    DIR_R = 2'd0,
    DIR_L = 2'd1,
    DIR_D = 2'd2,
    DIR_U = 2'd3
  } dir_t;

  // Browser command codes
  typedef enum logic [3:0] {
    GC_NONE        = 4'd0,
    GC_BACK        = 4'd1,
    GC_FORWARD     = 4'd2,
    GC_RELOAD      = 4'd3,
    GC_NEW_TAB     = 4'd4,
    GC_CLOSE_TAB   = 4'd5,
    GC_RESTORE_TAB = 4'd6,
    GC_PREV_TAB    = 4'd7,
    GC_NEXT_TAB    = 4'd8,
    GC_HARD_RELOAD = 4'd9
  } gcode_t;

  // Register map: register index is paddr[2]
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam int unsigned THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd24;

  // Stroke sequence to command; one_st / two_st say how many strokes exist
  function automatic gcode_t lookup_cmd(input logic one_st, input logic two_st,
                                        input dir_t d0, input dir_t d1);
    gcode_t c;
    c = GC_NONE;
    if (one_st) begin
      case (d0)
        DIR_L:   c = GC_BACK;
        DIR_R:   c = GC_FORWARD;
        DIR_U:   c = GC_RELOAD;
        default: c = GC_NEW_TAB;
      endcase
    end else if (two_st) begin
      if (d0 == DIR_D && d1 == DIR_R) c = GC_CLOSE_TAB;
      else if (d0 == DIR_D && d1 == DIR_L) c = GC_RESTORE_TAB;
      else if (d0 == DIR_U && d1 == DIR_L) c = GC_PREV_TAB;
      else if (d0 == DIR_U && d1 == DIR_R) c = GC_NEXT_TAB;
      else if (d0 == DIR_R && d1 == DIR_L) c = GC_HARD_RELOAD;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mouse_gesture_recognizer.sv -----
// ----------------------------------------------------------------------------
// mouse_gesture_recognizer
// Recognises right-button drag gestures from a stream of pointer events and
// reports one result word per event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one pointer event word per accepted handshake
//   (in_valid high, in_stall low at a rising edge).
//   Output channel (out_*): exactly one result word per event, in order.
//   The APB port sets gestures_enabled (0x0) and stroke_threshold (0x4);
//   write it only while no event is in flight.
//   An accepted event is held in the input register and its result is
//   shown in the output register.
//   Throughput: one event per cycle while out_stall allows; the single state
//   update per event (two 17-bit subtractions, magnitude compares and the
//   stroke append) lies between the input register and the output register.
//   Stall: while out_stall holds a result, the input register keeps its word
//   and in_stall rises once it is full; nothing is dropped.
//   Reset (rst_n low, synchronous): tracking, stroke count and the pending
//   menu swallow clear, gestures enabled, threshold 24, both stages empty.
// ----------------------------------------------------------------------------
module mouse_gesture_recognizer #(
  parameter int unsigned MAX_STROKES = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // event input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_cmd,
  input  logic                        in_right_button,
  input  logic                        in_right_held,
  input  logic signed [15:0]          in_pos_x,
  input  logic signed [15:0]          in_pos_y,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_consumed,
  output logic                        out_gesture_done,
  output logic [3:0]                  out_command_code,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mgr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned CW  = $clog2(MAX_STROKES + 1);
  localparam int unsigned IW  = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
  localparam int unsigned IX1 = (MAX_STROKES > 1) ? 1 : 0;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_STROKES);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TWO = CW'((MAX_STROKES > 1) ? 2 : 1);

  // configuration registers
  logic                           enable_r;
  logic [mgr_pkg::THR_W-1:0]      thresh_r;

  // input stage
  logic                           s1_valid_r;
  logic [2:0]                     s1_cmd_r;
  logic                           s1_right_r;
  logic                           s1_held_r;
  logic signed [15:0]             s1_x_r;
  logic signed [15:0]             s1_y_r;

  // gesture state
  logic                           tracking_r, tracking_nxt;
  logic signed [15:0]             origin_x_r, origin_x_nxt;
  logic signed [15:0]             origin_y_r, origin_y_nxt;
  mgr_pkg::dir_t                  dirs_r [MAX_STROKES];
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           suppress_r, suppress_nxt;

  // output stage
  logic                           out_valid_r;
  logic                           consumed_r, consumed_nxt;
  logic                           done_r, done_nxt;
  mgr_pkg::gcode_t                code_r, code_nxt;

  logic                           advance;
  logic                           s1_fire;
  logic                           dir_we;
  logic [IW-1:0]                  dir_wa;
  mgr_pkg::dir_t                  new_dir;

  // handshake
  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign out_valid        = out_valid_r;
  assign out_consumed     = consumed_r;
  assign out_gesture_done = done_r;
  assign out_command_code = code_r;

  // APB register file
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      mgr_pkg::REG_ENABLE:    prdata = {31'd0, enable_r};
      mgr_pkg::REG_THRESHOLD: prdata = {17'd0, thresh_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      thresh_r <= mgr_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        mgr_pkg::REG_ENABLE:    enable_r <= pwdata[0];
        mgr_pkg::REG_THRESHOLD: thresh_r <= pwdata[mgr_pkg::THR_W-1:0];
        default:                ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r   <= in_cmd;
      s1_right_r <= in_right_button;
      s1_held_r  <= in_right_held;
      s1_x_r     <= in_pos_x;
      s1_y_r     <= in_pos_y;
    end
  end

  // event step: travel, direction and state update
  logic signed [16:0] dx, dy;
  logic        [16:0] ax, ay;
  logic               over_th;
  logic [CW-1:0]      cnt_m1;
  logic               differs;
  mgr_pkg::dir_t      last_dir;

  always_comb begin
    dx = 17'(s1_x_r) - 17'(origin_x_r);
    dy = 17'(s1_y_r) - 17'(origin_y_r);
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    over_th = (ax >= 17'(thresh_r)) || (ay >= 17'(thresh_r));
    if (ax > ay) new_dir = (!dx[16] && dx != '0) ? mgr_pkg::DIR_R : mgr_pkg::DIR_L;
    else         new_dir = (!dy[16] && dy != '0) ? mgr_pkg::DIR_D : mgr_pkg::DIR_U;
    cnt_m1   = count_r - CNT_ONE;
    last_dir = dirs_r[cnt_m1[IW-1:0]];
    differs  = (count_r == '0) || (last_dir != new_dir);
  end

  always_comb begin
    tracking_nxt = tracking_r;
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    count_nxt    = count_r;
    suppress_nxt = suppress_r;
    consumed_nxt = 1'b0;
    done_nxt     = 1'b0;
    code_nxt     = mgr_pkg::GC_NONE;
    dir_we       = 1'b0;
    dir_wa       = count_r[IW-1:0];

    if (s1_cmd_r == mgr_pkg::CMD_MENU) begin
      // swallow one context menu after a finished gesture
      if (suppress_r) begin
        suppress_nxt = 1'b0;
        consumed_nxt = 1'b1;
      end
    end else if (!enable_r) begin
      tracking_nxt = 1'b0;
    end else if (s1_cmd_r == mgr_pkg::CMD_PRESS && s1_right_r) begin
      tracking_nxt = 1'b1;
      origin_x_nxt = s1_x_r;
      origin_y_nxt = s1_y_r;
      count_nxt    = '0;
    end else if (s1_cmd_r == mgr_pkg::CMD_MOVE && tracking_r && s1_held_r) begin
      if (over_th) begin
        if (differs && count_r < CNT_MAX) begin
          dir_we    = 1'b1;
          count_nxt = count_r + CNT_ONE;
        end
        origin_x_nxt = s1_x_r;
        origin_y_nxt = s1_y_r;
      end
      consumed_nxt = (count_nxt != '0);
    end else if (s1_cmd_r == mgr_pkg::CMD_RELEASE && s1_right_r && tracking_r) begin
      tracking_nxt = 1'b0;
      if (count_r != '0) begin
        suppress_nxt = 1'b1;
        code_nxt     = mgr_pkg::lookup_cmd(count_r == CNT_ONE,
                                           (MAX_STROKES > 1) && (count_r == CNT_TWO),
                                           dirs_r[0], dirs_r[IX1]);
        count_nxt    = '0;
        consumed_nxt = 1'b1;
        done_nxt     = 1'b1;
      end
    end else if (s1_cmd_r == mgr_pkg::CMD_PRESS && !s1_right_r) begin
      tracking_nxt = 1'b0;
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r  <= 1'b0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      count_r     <= '0;
      suppress_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) out_valid_r <= s1_valid_r;
      if (s1_fire) begin
        tracking_r <= tracking_nxt;
        origin_x_r <= origin_x_nxt;
        origin_y_r <= origin_y_nxt;
        count_r    <= count_nxt;
        suppress_r <= suppress_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      consumed_r <= consumed_nxt;
      done_r     <= done_nxt;
      code_r     <= code_nxt;
      if (dir_we) dirs_r[dir_wa] <= new_dir;
    end
  end

  // checks
  a_done_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> consumed_r)
    else $error("finished gesture not consumed");

  a_code_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> code_r == mgr_pkg::GC_NONE)
    else $error("command code without finished gesture");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("stroke count beyond limit");

  a_done_arms_menu: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && done_nxt |=> suppress_r && !tracking_r && count_r == '0)
    else $error("gesture finish left state inconsistent");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without back-pressure");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse gesture recogniser testbench
// Drives pointer event words into the recogniser with random idle gaps and
// random result stalls, predicts every result word from its own model of the
// tracking and stroke state, and checks each result field by field. Runs a
// directed set of corner cases, then random gestures under several register
// settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned N_STROKES = 3;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [mgr_pkg::ADDR_W-1:0] ADDR_ENABLE = {mgr_pkg::REG_ENABLE, 2'b00};
  localparam logic [mgr_pkg::ADDR_W-1:0] ADDR_THRESHOLD = {mgr_pkg::REG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic            consumed;
    logic            done;
    mgr_pkg::gcode_t code;
  } verdict_t;

  // Tracks the gesture state and holds the verdicts still owed by the block
  class gesture_checker;
    bit enabled = 1'b1;
    logic [mgr_pkg::THR_W-1:0] thresh = mgr_pkg::THR_RESET;
    bit tracking = 1'b0;
    logic signed [15:0] org_x = '0;
    logic signed [15:0] org_y = '0;
    mgr_pkg::dir_t strokes [N_STROKES];
    int unsigned n_strokes = 0;
    bit menu_pending = 1'b0;
    verdict_t awaited_verdicts [$];
    int errors = 0;
    int n_checked = 0;
    int n_gestures = 0;
    int n_matched = 0;

    function void set_register(logic idx, logic [31:0] value);
      if (idx == mgr_pkg::REG_ENABLE) enabled = value[0];
      else thresh = value[mgr_pkg::THR_W-1:0];
    endfunction

    // Command for the strokes held so far
    function mgr_pkg::gcode_t command_for();
      mgr_pkg::gcode_t c;
      c = mgr_pkg::GC_NONE;
      if (n_strokes == 1) begin
        case (strokes[0])
          mgr_pkg::DIR_L: c = mgr_pkg::GC_BACK;
          mgr_pkg::DIR_R: c = mgr_pkg::GC_FORWARD;
          mgr_pkg::DIR_U: c = mgr_pkg::GC_RELOAD;
          default:        c = mgr_pkg::GC_NEW_TAB;
        endcase
      end else if (n_strokes == 2) begin
        case ({strokes[0], strokes[1]})
          {mgr_pkg::DIR_D, mgr_pkg::DIR_R}: c = mgr_pkg::GC_CLOSE_TAB;
          {mgr_pkg::DIR_D, mgr_pkg::DIR_L}: c = mgr_pkg::GC_RESTORE_TAB;
          {mgr_pkg::DIR_U, mgr_pkg::DIR_L}: c = mgr_pkg::GC_PREV_TAB;
          {mgr_pkg::DIR_U, mgr_pkg::DIR_R}: c = mgr_pkg::GC_NEXT_TAB;
          {mgr_pkg::DIR_R, mgr_pkg::DIR_L}: c = mgr_pkg::GC_HARD_RELOAD;
          default: c = mgr_pkg::GC_NONE;
        endcase
      end
      return c;
    endfunction

    // Step the gesture state for one accepted event word
    function void recognise(logic [2:0] cmd, logic rb, logic rh,
                            logic signed [15:0] x, logic signed [15:0] y);
      verdict_t v;
      int dx, dy, ax, ay;
      mgr_pkg::dir_t d;
      v = '{consumed: 1'b0, done: 1'b0, code: mgr_pkg::GC_NONE};
      if (cmd == mgr_pkg::CMD_MENU) begin
        if (menu_pending) begin
          menu_pending = 1'b0;
          v.consumed = 1'b1;
        end
      end else if (!enabled) begin
        tracking = 1'b0;
      end else if (cmd == mgr_pkg::CMD_PRESS && rb) begin
        tracking = 1'b1;
        org_x = x;
        org_y = y;
        n_strokes = 0;
      end else if (cmd == mgr_pkg::CMD_MOVE && tracking && rh) begin
        dx = int'(x) - int'(org_x);
        dy = int'(y) - int'(org_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax >= int'(thresh) || ay >= int'(thresh)) begin
          // dominant axis; a tie goes vertical
          if (ax > ay) d = (dx > 0) ? mgr_pkg::DIR_R : mgr_pkg::DIR_L;
          else d = (dy > 0) ? mgr_pkg::DIR_D : mgr_pkg::DIR_U;
          if (n_strokes == 0 || strokes[n_strokes-1] != d) begin
            if (n_strokes < N_STROKES) begin
              strokes[n_strokes] = d;
              n_strokes++;
            end
          end
          org_x = x;
          org_y = y;
        end
        v.consumed = (n_strokes != 0);
      end else if (cmd == mgr_pkg::CMD_RELEASE && rb && tracking) begin
        tracking = 1'b0;
        if (n_strokes != 0) begin
          menu_pending = 1'b1;
          v.code = command_for();
          n_strokes = 0;
          v.consumed = 1'b1;
          v.done = 1'b1;
        end
      end else if (cmd == mgr_pkg::CMD_PRESS && !rb) begin
        tracking = 1'b0;
      end
      awaited_verdicts = {awaited_verdicts, v};
    endfunction

    function void check_verdict(logic consumed, logic done, logic [3:0] code);
      verdict_t e;
      if (awaited_verdicts.size() == 0) begin
        $error("result word with no event outstanding");
        errors++;
        return;
      end
      e = awaited_verdicts.pop_front();
      n_checked++;
      if (e.done) n_gestures++;
      if (e.code != mgr_pkg::GC_NONE) n_matched++;
      if (consumed !== e.consumed) begin
        $error("consumed: expected %0d, got %0d", e.consumed, consumed);
        errors++;
      end
      if (done !== e.done) begin
        $error("gesture_done: expected %0d, got %0d", e.done, done);
        errors++;
      end
      if (code !== e.code) begin
        $error("command_code: expected %0d, got %0d", e.code, code);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_cmd;
  logic in_right_button, in_right_held;
  logic signed [15:0] in_pos_x, in_pos_y;
  logic out_valid, out_stall;
  logic out_consumed, out_gesture_done;
  logic [3:0] out_command_code;
  logic psel, penable, pwrite;
  logic [mgr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  gesture_checker chk = new();
  int cycle_count = 0;
  int n_sent = 0;
  int n_settings = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  mouse_gesture_recognizer #(.MAX_STROKES(N_STROKES)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_right_button  (in_right_button),
    .in_right_held    (in_right_held),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_consumed     (out_consumed),
    .out_gesture_done (out_gesture_done),
    .out_command_code (out_command_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Result side: random stall per word, checked at the accepting edge
  initial begin
    int w;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
      w = draw_wait(rx_quiet);
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      chk.check_verdict(out_consumed, out_gesture_done, out_command_code);
    end
  end

  // Send one event word; entered and left at a falling edge, valid left high
  task automatic send_event(logic [2:0] cmd, logic rb, logic rh,
                            logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_right_button <= rb;
    in_right_held <= rh;
    in_pos_x <= x;
    in_pos_y <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.recognise(cmd, rb, rh, x, y);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send_event(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
               16'($urandom), 16'($urandom));
  endtask

  task automatic apb_write(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (idx == mgr_pkg::REG_ENABLE) ? ADDR_ENABLE : ADDR_THRESHOLD;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    chk.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic en, int thr);
    apb_write(mgr_pkg::REG_ENABLE, 32'(en));
    apb_write(mgr_pkg::REG_THRESHOLD, 32'(thr));
    n_settings++;
  endtask

  // Wait for every owed result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Well-formed right drag with random strokes, noise mixed in
  task automatic run_gesture(int thr);
    logic signed [15:0] px, py;
    int steps, mag, off, d;
    px = 16'($urandom);
    py = 16'($urandom);
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'($urandom), px, py);
    steps = $urandom_range(1, 7);
    repeat (steps) begin
      d = $urandom_range(0, 3);
      mag = $urandom_range(0, 2 * thr + 1);
      off = ($urandom_range(0, 7) == 0) ? mag : $urandom_range(0, mag);
      if ($urandom_range(0, 1) == 1) off = -off;
      case (d)
        0: begin px = 16'(px + mag); py = 16'(py + off); end
        1: begin px = 16'(px - mag); py = 16'(py + off); end
        2: begin py = 16'(py + mag); px = 16'(px + off); end
        default: begin py = 16'(py - mag); px = 16'(px + off); end
      endcase
      if ($urandom_range(0, 11) == 0) send_noise();
      send_event(mgr_pkg::CMD_MOVE, 1'($urandom), $urandom_range(0, 9) != 0, px, py);
    end
    if ($urandom_range(0, 7) == 0) send_event(mgr_pkg::CMD_RELEASE, 1'b0, 1'b1, px, py);
    send_event(mgr_pkg::CMD_RELEASE, $urandom_range(0, 9) != 0, 1'($urandom), px, py);
    if ($urandom_range(0, 3) != 0)
      send_event(mgr_pkg::CMD_MENU, 1'($urandom), 1'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  // Stimulus
  initial begin
    int ph, thr, target;
    logic en;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= mgr_pkg::CMD_OTHER;
    in_right_button <= 1'b0;
    in_right_held <= 1'b0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset threshold, stroke rules, limit, menu swallow
    configure(1'b1, 24);
    send_event(mgr_pkg::CMD_MENU, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b0, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, 16'sd100, 16'sd100);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd123, 16'sd100);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd124, 16'sd100);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd148, 16'sd100);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd148, 16'sd76);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b0, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd124, 16'sd100);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd100, 16'sd100);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b1, 16'sd100, 16'sd100);
    send_event(mgr_pkg::CMD_MENU, 1'b1, 1'b0, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_MENU, 1'b1, 1'b0, 16'sd0, 16'sd0);
    // extreme positions: tie goes down, then left
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, -16'sd32768, -16'sd32768);
    send_event(mgr_pkg::CMD_MOVE, 1'b0, 1'b1, 16'sd32767, 16'sd32767);
    send_event(mgr_pkg::CMD_MOVE, 1'b0, 1'b1, -16'sd32768, 16'sd32767);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b0, -16'sd1, -16'sd1);
    send_event(mgr_pkg::CMD_OTHER, 1'b1, 1'b1, -16'sd1, -16'sd1);
    send_event(3'd5, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_event(3'd6, 1'b0, 1'b0, 16'sd0, 16'sd0);
    send_event(3'd7, 1'b1, 1'b0, 16'sd0, 16'sd0);
    // plain right click
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, 16'sd5, 16'sd5);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b1, 16'sd5, 16'sd5);
    // other-button release keeps tracking, other-button press drops it
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, 16'sd5, 16'sd5);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd35, 16'sd5);
    send_event(mgr_pkg::CMD_RELEASE, 1'b0, 1'b1, 16'sd35, 16'sd5);
    send_event(mgr_pkg::CMD_PRESS, 1'b0, 1'b1, 16'sd35, 16'sd5);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b1, 16'sd35, 16'sd5);
    drain();

    // Zero threshold: a move with no travel is an up stroke
    configure(1'b1, 0);
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b0, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b0, 16'sd0, 16'sd0);
    drain();

    // Disabled: everything passes, swallow still pending
    configure(1'b0, 32767);
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, 16'sd100, 16'sd0);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b1, 16'sd100, 16'sd0);
    send_event(mgr_pkg::CMD_MENU, 1'b1, 1'b1, 16'sd100, 16'sd0);
    drain();

    // Largest threshold
    configure(1'b1, 32767);
    send_event(mgr_pkg::CMD_PRESS, 1'b1, 1'b1, -16'sd32768, 16'sd0);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, -16'sd2, 16'sd0);
    send_event(mgr_pkg::CMD_MOVE, 1'b1, 1'b1, -16'sd1, 16'sd0);
    send_event(mgr_pkg::CMD_RELEASE, 1'b1, 1'b1, -16'sd1, 16'sd0);
    send_event(mgr_pkg::CMD_MENU, 1'b0, 1'b0, 16'sd0, 16'sd0);
    drain();

    // Random gestures under several settings
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: thr = 1;
        1: thr = 32767;
        2: thr = $urandom_range(200, 4000);
        default: thr = $urandom_range(2, 64);
      endcase
      en = (ph != 5);
      configure(en, thr);
      target = n_sent + 100;
      while (n_sent < target) begin
        if ($urandom_range(0, 9) < 8) run_gesture(thr);
        else send_noise();
      end
      drain();
    end

    $display("Checked %0d result words from %0d events under %0d register settings.",
             chk.n_checked, n_sent, n_settings);
    $display("%0d gestures finished, %0d of them mapped to a command.",
             chk.n_gestures, chk.n_matched);
    if (chk.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mgr_pkg.sv
hw/rtl/mouse_gesture_recognizer.sv
test/testbench.sv
